// ===== design/b64d_pkg.sv =====
`timescale 1ns / 1ps

package b64d_pkg;

  // width of the saturating byte counter, equal to the decoded_count field
  localparam int ByteCountBits = 20;

  localparam int CharW    = 8;
  localparam int SextetW  = 7;
  localparam int AccW     = 18;
  localparam int WordW    = 24;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [SextetW-1:0] SextetPad = 7'd64;
  localparam logic [SextetW-1:0] SextetBad = 7'd65;

  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChPad   = 8'h3D;

  typedef enum logic [2:0] {
    StOk           = 3'd0,
    StBadChar      = 3'd1,
    StOverPad      = 3'd2,
    StDataAfterPad = 3'd3,
    StPadMid       = 3'd4,
    StIncomplete   = 3'd5
  } status_e;

  // work handed from the front end to the back end: bytes of one group
  // and/or the closing status item
  typedef struct packed {
    logic [WordW-1:0]         word;
    logic [1:0]               num_bytes;
    logic                     has_status;
    status_e                  status;
    logic [ByteCountBits-1:0] count;
  } job_t;

  function automatic logic [SextetW-1:0] char_to_sextet(input logic [CharW-1:0] ch);
    logic [SextetW-1:0] s;
    s = SextetBad;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s = SextetW'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s = SextetW'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s = SextetW'(ch - 8'h30 + 8'd52);
    end else if (ch == ChPlus) begin
      s = 7'd62;
    end else if (ch == ChSlash) begin
      s = 7'd63;
    end else if (ch == ChPad) begin
      s = SextetPad;
    end
    return s;
  endfunction

endpackage

// ===== design/b64d_char_if.sv =====
`timescale 1ns / 1ps

interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

// ===== design/b64d_byte_if.sv =====
`timescale 1ns / 1ps

interface b64d_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        end_of_message;
  logic [2:0]  status;
  logic [19:0] decoded_count;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, output status, output decoded_count,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, input status, input decoded_count,
                  output ready);
endinterface

// ===== design/b64d_front.sv =====
`timescale 1ns / 1ps

module b64d_front
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_char_if.sink   chars_i,
  input  logic        job_ready_i,
  output logic        job_valid_o,
  output job_t        job_o
);

  logic [AccW-1:0]          acc_q, acc_d;
  logic [1:0]               pos_q, pos_d;
  logic [1:0]               pad_q, pad_d;
  logic                     pdone_q, pdone_d;
  status_e                  err_q, err_d;
  logic [ByteCountBits-1:0] bc_q, bc_d;

  logic                     accept;
  logic [SextetW-1:0]       sext;
  logic                     advance;
  logic [5:0]               val;
  logic [ByteCountBits:0]   sum;

  assign chars_i.ready = job_ready_i;
  assign accept        = chars_i.valid & job_ready_i;
  assign sext          = char_to_sextet(chars_i.char_code);

  always_comb begin
    acc_d   = acc_q;
    pos_d   = pos_q;
    pad_d   = pad_q;
    pdone_d = pdone_q;
    err_d   = err_q;
    bc_d    = bc_q;
    advance = 1'b0;
    val     = '0;
    sum     = '0;
    job_o   = '0;
    if (accept) begin
      if (err_d == StOk && pdone_q) begin
        err_d = StPadMid;
      end
      if (err_d == StOk) begin
        if (pad_q != 2'd0 && sext != SextetPad) begin
          err_d = StDataAfterPad;
        end else if (sext == SextetBad) begin
          err_d = StBadChar;
        end else if (sext == SextetPad) begin
          if (pos_q < 2'd2) begin
            err_d = StOverPad;
          end else begin
            pad_d   = pad_q + 2'd1;
            advance = 1'b1;
          end
        end else begin
          val     = sext[5:0];
          advance = 1'b1;
        end
        if (advance) begin
          if (pos_q != 2'd3) begin
            acc_d = {acc_q[AccW-7:0], val};
            pos_d = pos_q + 2'd1;
          end else begin
            job_o.word      = {acc_q, val};
            job_o.num_bytes = 2'd3 - pad_d;
            sum  = {1'b0, bc_q} + (ByteCountBits+1)'(job_o.num_bytes);
            bc_d = sum[ByteCountBits] ? {ByteCountBits{1'b1}} : sum[ByteCountBits-1:0];
            if (pad_d != 2'd0) begin
              pdone_d = 1'b1;
            end
            acc_d = '0;
            pos_d = 2'd0;
            pad_d = 2'd0;
          end
        end
      end
      if (chars_i.final_char) begin
        if (err_d == StOk && pos_d != 2'd0) begin
          err_d = StIncomplete;
        end
        job_o.has_status = 1'b1;
        job_o.status     = err_d;
        job_o.count      = (err_d == StOk) ? bc_d : '0;
        acc_d   = '0;
        pos_d   = 2'd0;
        pad_d   = 2'd0;
        pdone_d = 1'b0;
        err_d   = StOk;
        bc_d    = '0;
      end
    end
  end

  assign job_valid_o = accept & (job_o.has_status | (job_o.num_bytes != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pos_q   <= 2'd0;
      pad_q   <= 2'd0;
      pdone_q <= 1'b0;
      err_q   <= StOk;
      bc_q    <= '0;
    end else begin
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      pad_q   <= pad_d;
      pdone_q <= pdone_d;
      err_q   <= err_d;
      bc_q    <= bc_d;
    end
  end

endmodule

// ===== design/b64d_queue.sv =====
`timescale 1ns / 1ps

module b64d_queue
  import b64d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                 entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d;
  logic [QueuePtrW-1:0] rd_q, rd_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic                 do_pop;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = entries_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/b64d_back.sv =====
`timescale 1ns / 1ps

module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  b64d_byte_if.source bytes_o
);

  logic [1:0]               idx_q, idx_d;
  logic                     ovalid_q, ovalid_d;
  logic [7:0]               byte_q, byte_d;
  logic                     bvalid_q, bvalid_d;
  logic                     eom_q, eom_d;
  status_e                  st_q, st_d;
  logic [ByteCountBits-1:0] cnt_q, cnt_d;

  logic load, take, is_byte, last;

  assign load    = ~ovalid_q | bytes_o.ready;
  assign take    = load & job_valid_i;
  assign is_byte = idx_q < job_i.num_bytes;
  assign last    = is_byte ? ((idx_q == job_i.num_bytes - 2'd1) & ~job_i.has_status) : 1'b1;
  assign job_pop_o = take & last;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    byte_d   = byte_q;
    bvalid_d = bvalid_q;
    eom_d    = eom_q;
    st_d     = st_q;
    cnt_d    = cnt_q;
    if (load) begin
      ovalid_d = job_valid_i;
    end
    if (take) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
      if (is_byte) begin
        case (idx_q)
          2'd0:    byte_d = job_i.word[23:16];
          2'd1:    byte_d = job_i.word[15:8];
          default: byte_d = job_i.word[7:0];
        endcase
        bvalid_d = 1'b1;
        eom_d    = 1'b0;
        st_d     = StOk;
        cnt_d    = '0;
      end else begin
        byte_d   = '0;
        bvalid_d = 1'b0;
        eom_d    = 1'b1;
        st_d     = job_i.status;
        cnt_d    = job_i.count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    bvalid_q <= bvalid_d;
    eom_q    <= eom_d;
    st_q     <= st_d;
    cnt_q    <= cnt_d;
  end

  assign bytes_o.valid          = ovalid_q;
  assign bytes_o.data_byte      = byte_q;
  assign bytes_o.byte_valid     = bvalid_q;
  assign bytes_o.end_of_message = eom_q;
  assign bytes_o.status         = st_q;
  assign bytes_o.decoded_count  = cnt_q;

endmodule

// ===== design/base64_stream_decoder.sv =====
`timescale 1ns / 1ps

// Streaming base64 decoder: takes one character per transaction on chars_i, with
// final_char marking the last character of a message, and delivers decoded
// bytes (most significant first, three per group of four, fewer for a padded
// group) followed by one status transaction that closes the message with the
// error code and the saturating byte count. After an error no further bytes are
// produced until the final character; bytes already delivered for a message that
// ends in error are to be dropped by the consumer. A character is accepted every
// cycle as long as the four-entry job queue between the character classifier
// and the output sequencer has room; the output side moves one transaction per
// cycle while the consumer is ready, so a full group yields three output
// transactions per four characters and the final character of a message up to
// four, which the queue absorbs.

module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_char_if.sink   chars_i,
  b64d_byte_if.source bytes_o
);

  // front end to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to back end
  logic head_valid;
  job_t head_job;
  logic pop;

  // classifies each character and keeps group state, emits a job per group
  // completion or final character
  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chars_i     (chars_i),
    .job_ready_i (~q_full),
    .job_valid_o (push),
    .job_o       (push_job)
  );

  // short job queue so input and output can stall independently
  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  // turns each job into byte transactions and the closing status transaction
  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .bytes_o     (bytes_o)
  );

`ifndef SYNTH
  // the queue is never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue written while full");

  // status transactions always close the message
  a_status_eom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_o.valid && !bytes_o.byte_valid) |-> bytes_o.end_of_message)
    else $error("status transaction without end of message");

  // an error status reports no byte count
  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_o.valid && !bytes_o.byte_valid && bytes_o.status != StOk)
      |-> (bytes_o.decoded_count == '0))
    else $error("error status with nonzero count");

  // a job is only taken out of the queue when one is present
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty job queue");
`endif

endmodule

// ===== dv/b64d_decode_checker.sv =====
`timescale 1ns / 1ps

module b64d_decode_checker
  import b64d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  b64d_char_if char_bus,
  b64d_byte_if byte_bus,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   status_seen_o
);

  localparam logic [ByteCountBits-1:0] CountMax = '1;

  typedef struct packed {
    logic [7:0]               data_byte;
    logic                     byte_valid;
    logic                     end_of_message;
    status_e                  status;
    logic [ByteCountBits-1:0] decoded_count;
  } decoded_t;

  decoded_t decoded_q[$];

  // decoder state, one message at a time
  logic [AccW-1:0]          acc;
  logic [1:0]               grp_pos;
  logic [1:0]               pad_seen;
  logic                     pad_group_done;
  status_e                  msg_err;
  logic [ByteCountBits-1:0] msg_bytes;

  function automatic void clear_msg();
    acc            = '0;
    grp_pos        = '0;
    pad_seen       = '0;
    pad_group_done = 1'b0;
    msg_err        = StOk;
    msg_bytes      = '0;
  endfunction

  // bit 6 set: not one of the 64 data characters
  function automatic logic [6:0] sextet_value(input logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5a) return {1'b0, 6'(ch - 8'h41)};
    if (ch >= 8'h61 && ch <= 8'h7a) return {1'b0, 6'(ch - 8'h61 + 8'd26)};
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b0, 6'(ch - 8'h30 + 8'd52)};
    if (ch == ChPlus) return 7'd62;
    if (ch == ChSlash) return 7'd63;
    return 7'h40;
  endfunction

  function automatic void predict_char(input logic [7:0] ch, input logic fin);
    logic [6:0]       sx;
    logic             adv;
    logic [5:0]       val;
    logic [WordW-1:0] word;
    int               nb;
    decoded_t         r;
    sx   = sextet_value(ch);
    adv  = 1'b0;
    val  = '0;
    word = '0;
    nb   = 0;
    // anything behind a finished padded group
    if (msg_err == StOk && pad_group_done) msg_err = StPadMid;
    if (msg_err == StOk) begin
      if (pad_seen != 0 && ch != ChPad) begin
        msg_err = StDataAfterPad;
      end else if (ch == ChPad) begin
        if (grp_pos < 2) begin
          msg_err = StOverPad;
        end else begin
          pad_seen = pad_seen + 2'd1;
          adv      = 1'b1;
        end
      end else if (sx[6]) begin
        msg_err = StBadChar;
      end else begin
        val = sx[5:0];
        adv = 1'b1;
      end
      if (adv) begin
        if (grp_pos != 2'd3) begin
          acc     = {acc[AccW-7:0], val};
          grp_pos = grp_pos + 2'd1;
        end else begin
          word = {acc, val};
          nb   = 3 - int'(pad_seen);
          for (int i = 0; i < nb; i++) begin
            r            = '0;
            r.data_byte  = word[WordW-1-8*i -: 8];
            r.byte_valid = 1'b1;
            decoded_q.push_back(r);
            if (msg_bytes != CountMax) msg_bytes = msg_bytes + 1'b1;
          end
          if (pad_seen != 0) pad_group_done = 1'b1;
          acc      = '0;
          grp_pos  = '0;
          pad_seen = '0;
        end
      end
    end
    if (fin) begin
      if (msg_err == StOk && grp_pos != 0) msg_err = StIncomplete;
      r                = '0;
      r.end_of_message = 1'b1;
      r.status         = msg_err;
      r.decoded_count  = (msg_err == StOk) ? msg_bytes : '0;
      decoded_q.push_back(r);
      clear_msg();
    end
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  initial begin
    clear_msg();
    fail_count_o  = 0;
    pending_o     = 0;
    checked_o     = 0;
    status_seen_o = 0;
  end

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni) begin
      if (byte_bus.valid && byte_bus.ready) begin
        if (decoded_q.size() == 0) begin
          $error("output transaction with nothing expected: byte %0h, status %0d",
                 byte_bus.data_byte, byte_bus.status);
          fail_count_o++;
        end else begin
          want = decoded_q.pop_front();
          checked_o++;
          if (want.end_of_message) status_seen_o++;
          fail_count_o += field_differs("data_byte", 32'(want.data_byte),
                                        32'(byte_bus.data_byte));
          fail_count_o += field_differs("byte_valid", 32'(want.byte_valid),
                                        32'(byte_bus.byte_valid));
          fail_count_o += field_differs("end_of_message", 32'(want.end_of_message),
                                        32'(byte_bus.end_of_message));
          fail_count_o += field_differs("status", 32'(want.status),
                                        32'(byte_bus.status));
          fail_count_o += field_differs("decoded_count", 32'(want.decoded_count),
                                        32'(byte_bus.decoded_count));
        end
      end
      // the queue and the output register lie between them, so a character never answers on its own edge
      if (char_bus.valid && char_bus.ready) begin
        predict_char(char_bus.char_code, char_bus.final_char);
      end
      pending_o = decoded_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb
  import b64d_pkg::*;
();

  // random characters after the directed cases
  localparam int RandomItems = 280;
  // cycles in a row without any transaction before the run is declared hung
  localparam int IdleLimit   = 2000;
  // settle time once nothing is expected
  localparam int DrainCycles = 10;

  // how a random message is shaped before it is sent
  typedef enum int {
    MsgClean     = 0,
    MsgNoise     = 1,
    MsgStrayPad  = 2,
    MsgTruncated = 3,
    MsgPastPad   = 4,
    MsgGarbage   = 5
  } msg_kind_e;

  logic clk_i;
  logic rst_ni;

  b64d_char_if char_bus ();
  b64d_byte_if byte_bus ();

  int fail_count;
  int pending;
  int checked;
  int status_seen;

  int   chars_sent;
  int   msgs_sent;
  int   rand_target;
  int   idle_cycles;
  int   stall_left;
  logic calm;

  // characters of the message being sent, final flag goes on the last one
  logic [7:0] msg_q[$];

  base64_stream_decoder i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .chars_i (char_bus),
    .bytes_o (byte_bus)
  );

  // watches both channels, predicts and compares
  b64d_decode_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_bus      (char_bus),
    .byte_bus      (byte_bus),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .status_seen_o (status_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // index 0..63 to its character in the standard alphabet
  function automatic logic [7:0] b64_char(input int unsigned idx);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    if (idx == 62) return ChPlus;
    return ChSlash;
  endfunction

  // one character transaction; valid only drops when a gap is wanted
  task automatic send_char(input logic [7:0] ch, input logic fin);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_bus.valid      <= 1'b1;
    char_bus.char_code  <= ch;
    char_bus.final_char <= fin;
    @(posedge clk_i);
    while (!char_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    chars_sent++;
  endtask

  // send msg_q as one message; some messages run with no idling at all
  task automatic send_queue();
    calm = ($urandom_range(0, 4) == 0);
    foreach (msg_q[i]) send_char(msg_q[i], i == msg_q.size() - 1);
    msgs_sent++;
  endtask

  task automatic send_text(input string s);
    msg_q.delete();
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    send_queue();
  endtask

  task automatic send_lone(input logic [7:0] ch);
    msg_q.delete();
    msg_q.push_back(ch);
    send_queue();
  endtask

  // mostly well-formed groups with random content, the rest broken on purpose
  task automatic build_random_msg();
    int        groups;
    int        r;
    int        len;
    msg_kind_e kind;
    msg_q.delete();
    groups = $urandom_range(1, 4);
    repeat (groups * 4) msg_q.push_back(b64_char($urandom_range(0, 63)));
    // one or two pad characters closing the last group
    if ($urandom_range(0, 2) == 0) begin
      msg_q[msg_q.size()-1] = ChPad;
      if ($urandom_range(0, 1) == 1) msg_q[msg_q.size()-2] = ChPad;
    end
    r    = $urandom_range(0, 9);
    kind = (r < 5) ? MsgClean : msg_kind_e'(r - 4);
    case (kind)
      MsgNoise: begin
        // any byte value, mostly invalid characters
        msg_q[$urandom_range(0, msg_q.size()-1)] = 8'($urandom_range(0, 255));
      end
      MsgStrayPad: begin
        msg_q[$urandom_range(0, msg_q.size()-1)] = ChPad;
      end
      MsgTruncated: begin
        // leaves the last group unfinished
        repeat ($urandom_range(1, 3)) begin
          if (msg_q.size() > 1) void'(msg_q.pop_back());
        end
      end
      MsgPastPad: begin
        // a padded group followed by more data
        msg_q[msg_q.size()-1] = ChPad;
        repeat ($urandom_range(1, 4)) msg_q.push_back(b64_char($urandom_range(0, 63)));
      end
      MsgGarbage: begin
        msg_q.delete();
        len = $urandom_range(1, 6);
        repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
      end
    endcase
  endtask

  // output side: random stalls, no new one starts while a calm message is running
  initial begin
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        byte_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        byte_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // hang detection: no transaction on either channel for too long
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((char_bus.valid && char_bus.ready) || (byte_bus.valid && byte_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: %0d idle cycles, %0d results outstanding", idle_cycles, pending);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    char_bus.valid      = 1'b0;
    char_bus.char_code  = '0;
    char_bus.final_char = 1'b0;
    byte_bus.ready      = 1'b0;
    calm                = 1'b0;
    chars_sent          = 0;
    msgs_sent           = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    send_text("+/Az");     // full group, alphabet edges
    send_text("09a=");     // single pad, two bytes
    send_text("TQ==");     // double pad, one byte
    send_text("=");        // pad at the start of a group
    send_text("Q=");       // pad in the second position
    send_text("QU=A");     // data behind a pad in the same group
    send_text("QQ==Q");    // character after a finished padded group
    send_lone(8'h00);      // lowest char code, invalid
    send_lone(8'hff);      // highest char code, invalid
    send_text("QUJ");      // message ends inside a group

    // random part
    rand_target = chars_sent + RandomItems;
    while (chars_sent < rand_target) begin
      build_random_msg();
      send_queue();
    end
    char_bus.valid <= 1'b0;

    // drain: everything predicted has to show up, the watchdog bounds this
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d messages, %0d characters: clean groups, padding, noise, truncation",
             msgs_sent, chars_sent);
    $display("compared %0d output transactions, %0d of them closing status",
             checked, status_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/b64d_pkg.sv
design/b64d_char_if.sv
design/b64d_byte_if.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
dv/b64d_decode_checker.sv
dv/tb.sv
